// ----- rtl/core/gtt_pkg.sv -----
// gtt_pkg: shared types and constants of the generational ticket table
// slot row layout, action and status codes, evaluation result struct
// no dependencies
package gtt_pkg;

  localparam int CAP_W   = 5;
  localparam int COUNT_W = 5;
  localparam int GEN_W   = 32;
  localparam int TAG_W   = 64;
  localparam int OIDX_W  = 4;

  typedef enum logic [1:0] {
    ACT_SUBMIT = 2'd0,
    ACT_POLL   = 2'd1,
    ACT_RETIRE = 2'd2,
    ACT_QUERY  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    STAT_OK            = 3'd0,
    STAT_EMPTY         = 3'd1,
    STAT_FULL          = 3'd2,
    STAT_INVALID       = 3'd3,
    STAT_NOT_RETIRABLE = 3'd4
  } status_t;

  localparam logic [1:0] PHASE_INVALID = 2'd0;
  localparam logic [1:0] PHASE_PENDING = 2'd1;
  localparam logic [1:0] PHASE_READY   = 2'd2;
  localparam logic [1:0] PHASE_RETIRED = 2'd3;

  localparam logic [GEN_W-1:0] GEN_FIRST = 32'd1;
  localparam logic [GEN_W-1:0] GEN_MAX   = 32'hFFFF_FFFF;

  typedef struct packed {
    logic             occupied;
    logic [1:0]       phase;
    logic [GEN_W-1:0] generation;
    logic [TAG_W-1:0] tag;
  } slot_row_t;

  localparam slot_row_t RESET_ROW = '{
    occupied:   1'b0,
    phase:      PHASE_RETIRED,
    generation: GEN_FIRST,
    tag:        '0
  };

  typedef struct packed {
    logic             hit;
    logic             we;
    slot_row_t        row;
    status_t          status;
    logic [1:0]       state;
    logic [TAG_W-1:0] tag;
    logic [GEN_W-1:0] gen;
    logic             live_inc;
    logic             live_dec;
    logic             pend_inc;
    logic             pend_dec;
    logic             rdy_inc;
    logic             rdy_dec;
  } eval_res_t;

endpackage

// ----- rtl/core/generational_ticket_table.sv -----
// generational_ticket_table: top level, sequencer, totals and result register
// depends on gtt_pkg, gtt_slot_mem and gtt_slot_eval
//
// usage:
//   input channel in_valid / in_stall carries one action word (submit, poll,
//   retire, query); a word is taken when in_valid is high and in_stall low
//   result channel out_valid / out_stall returns exactly one word per action
//   cfg_valid / cfg_ready writes capacity_in_use; cfg_ready is always high
// sequence:
//   poll, retire and query read their slot once: accept, slot read,
//   evaluate and write back, result load
//   submit scans slots from 0, one slot read and evaluate per slot, through
//   the single read port of the slot memory, ending at the first free slot,
//   or with full status when all c slots of the capacity are taken
//   rejected words (empty submit, zero capacity, null or out of range
//   ticket) skip the memory
// reset:
//   synchronous rst_n; afterwards a clearing pass writes every slot row,
//   with in_stall high; capacity returns to 16
// stall:
//   the result register holds while out_stall is high; a next word is still
//   taken and waits in its result stage until the register frees
module generational_ticket_table #(
  parameter int SLOT_COUNT = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_action,
  input  logic [15:0]                   in_ticket_index,
  input  logic [31:0]                   in_ticket_generation,
  input  logic [63:0]                   in_user_tag,
  input  logic [15:0]                   in_staging_length,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    out_status,
  output logic [3:0]                    out_index,
  output logic [31:0]                   out_generation,
  output logic [1:0]                    out_ticket_state,
  output logic [63:0]                   out_tag_out,
  output logic [4:0]                    out_live_count,
  output logic [4:0]                    out_pending_count,
  output logic [4:0]                    out_ready_count,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gtt_pkg::CAP_W-1:0]     cfg_capacity_in_use
);
  import gtt_pkg::*;

  localparam int IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
  localparam int SCAN_W = (IDX_W + 1 > CAP_W) ? IDX_W + 1 : CAP_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_READ  = 5'b00100,
    S_EVAL  = 5'b01000,
    S_PUSH  = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  addr_r, addr_nxt;
  action_t           act_r, act_nxt;
  logic [GEN_W-1:0]  gen_q_r, gen_q_nxt;
  logic [TAG_W-1:0]  tag_q_r, tag_q_nxt;
  logic [CAP_W-1:0]  cap_r, cap_nxt;
  logic [CNT_W-1:0]  live_r, live_nxt;
  logic [CNT_W-1:0]  pend_r, pend_nxt;
  logic [CNT_W-1:0]  rdy_r, rdy_nxt;

  status_t           res_status_r, res_status_nxt;
  logic [OIDX_W-1:0] res_index_r, res_index_nxt;
  logic [GEN_W-1:0]  res_gen_r, res_gen_nxt;
  logic [1:0]        res_state_r, res_state_nxt;
  logic [TAG_W-1:0]  res_tag_r, res_tag_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [2:0]        out_status_r;
  logic [3:0]        out_index_r;
  logic [31:0]       out_generation_r;
  logic [1:0]        out_ticket_state_r;
  logic [63:0]       out_tag_out_r;
  logic [4:0]        out_live_count_r;
  logic [4:0]        out_pending_count_r;
  logic [4:0]        out_ready_count_r;

  logic              mem_we;
  slot_row_t         mem_wdata;
  slot_row_t         mem_rdata;
  eval_res_t         ev;

  logic              in_fire;
  logic              out_load;
  logic [SCAN_W-1:0] cap_eff;
  logic [SCAN_W-1:0] scan_next;
  logic              idx_ok;

  gtt_slot_mem #(
    .SLOT_COUNT (SLOT_COUNT),
    .IDX_W      (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (addr_r),
    .wdata (mem_wdata),
    .raddr (addr_r),
    .rdata (mem_rdata)
  );

  gtt_slot_eval u_eval (
    .act   (act_r),
    .row   (mem_rdata),
    .gen_q (gen_q_r),
    .tag_q (tag_q_r),
    .res   (ev)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_load  = (state_r == S_PUSH) && (!out_valid_r || !out_stall);

  assign cap_eff   = (SCAN_W'(cap_r) < SCAN_W'(SLOT_COUNT)) ? SCAN_W'(cap_r)
                                                            : SCAN_W'(SLOT_COUNT);
  assign scan_next = SCAN_W'(addr_r) + SCAN_W'(1);
  assign idx_ok    = ({1'b0, in_ticket_index} < 17'(SLOT_COUNT));

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = ev.row;
    if (state_r == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_wdata = RESET_ROW;
    end else if (state_r == S_EVAL) begin
      mem_we = ev.we;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    addr_nxt       = addr_r;
    act_nxt        = act_r;
    gen_q_nxt      = gen_q_r;
    tag_q_nxt      = tag_q_r;
    cap_nxt        = cap_r;
    live_nxt       = live_r;
    pend_nxt       = pend_r;
    rdy_nxt        = rdy_r;
    res_status_nxt = res_status_r;
    res_index_nxt  = res_index_r;
    res_gen_nxt    = res_gen_r;
    res_state_nxt  = res_state_r;
    res_tag_nxt    = res_tag_r;

    if (cfg_valid && cfg_ready) begin
      cap_nxt = cfg_capacity_in_use;
    end

    unique case (state_r)
      S_CLEAR: begin
        addr_nxt = addr_r + IDX_W'(1);
        if (addr_r == LAST_IDX) begin
          addr_nxt  = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          act_nxt        = action_t'(in_action);
          gen_q_nxt      = in_ticket_generation;
          tag_q_nxt      = in_user_tag;
          res_status_nxt = STAT_OK;
          res_index_nxt  = '0;
          res_gen_nxt    = '0;
          res_state_nxt  = PHASE_INVALID;
          res_tag_nxt    = '0;
          if (action_t'(in_action) == ACT_SUBMIT) begin
            addr_nxt = '0;
            if (in_staging_length == '0) begin
              res_status_nxt = STAT_EMPTY;
              state_nxt      = S_PUSH;
            end else if (cap_eff == '0) begin
              res_status_nxt = STAT_FULL;
              state_nxt      = S_PUSH;
            end else begin
              state_nxt = S_READ;
            end
          end else begin
            addr_nxt = IDX_W'(in_ticket_index);
            if (in_ticket_generation == '0 || !idx_ok) begin
              res_status_nxt = STAT_INVALID;
              state_nxt      = S_PUSH;
            end else begin
              state_nxt = S_READ;
            end
          end
        end
      end
      S_READ: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (act_r == ACT_SUBMIT && !ev.hit) begin
          if (scan_next >= cap_eff) begin
            res_status_nxt = STAT_FULL;
            state_nxt      = S_PUSH;
          end else begin
            addr_nxt  = addr_r + IDX_W'(1);
            state_nxt = S_READ;
          end
        end else begin
          res_status_nxt = ev.status;
          res_state_nxt  = ev.state;
          res_tag_nxt    = ev.tag;
          if (act_r == ACT_SUBMIT) begin
            res_index_nxt = OIDX_W'(addr_r);
            res_gen_nxt   = ev.gen;
          end
          if (ev.live_inc) begin
            live_nxt = live_r + CNT_W'(1);
          end else if (ev.live_dec && live_r != '0) begin
            live_nxt = live_r - CNT_W'(1);
          end
          if (ev.pend_inc) begin
            pend_nxt = pend_r + CNT_W'(1);
          end else if (ev.pend_dec && pend_r != '0) begin
            pend_nxt = pend_r - CNT_W'(1);
          end
          if (ev.rdy_inc) begin
            rdy_nxt = rdy_r + CNT_W'(1);
          end else if (ev.rdy_dec && rdy_r != '0) begin
            rdy_nxt = rdy_r - CNT_W'(1);
          end
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
        addr_nxt  = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      addr_r      <= '0;
      act_r       <= ACT_SUBMIT;
      cap_r       <= CAP_W'(16);
      live_r      <= '0;
      pend_r      <= '0;
      rdy_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      act_r       <= act_nxt;
      cap_r       <= cap_nxt;
      live_r      <= live_nxt;
      pend_r      <= pend_nxt;
      rdy_r       <= rdy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    gen_q_r      <= gen_q_nxt;
    tag_q_r      <= tag_q_nxt;
    res_status_r <= res_status_nxt;
    res_index_r  <= res_index_nxt;
    res_gen_r    <= res_gen_nxt;
    res_state_r  <= res_state_nxt;
    res_tag_r    <= res_tag_nxt;
    if (out_load) begin
      out_status_r        <= res_status_r;
      out_index_r         <= res_index_r;
      out_generation_r    <= res_gen_r;
      out_ticket_state_r  <= res_state_r;
      out_tag_out_r       <= res_tag_r;
      out_live_count_r    <= COUNT_W'(live_r);
      out_pending_count_r <= COUNT_W'(pend_r);
      out_ready_count_r   <= COUNT_W'(rdy_r);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_index         = out_index_r;
  assign out_generation    = out_generation_r;
  assign out_ticket_state  = out_ticket_state_r;
  assign out_tag_out       = out_tag_out_r;
  assign out_live_count    = out_live_count_r;
  assign out_pending_count = out_pending_count_r;
  assign out_ready_count   = out_ready_count_r;

endmodule

// ----- rtl/core/gtt_slot_mem.sv -----
// gtt_slot_mem: slot row storage, one write port and one registered read port
// depends on gtt_pkg for the row type
module gtt_slot_mem #(
  parameter int SLOT_COUNT = 16,
  parameter int IDX_W      = 4
) (
  input  logic               clk,
  input  logic               we,
  input  logic [IDX_W-1:0]   waddr,
  input  gtt_pkg::slot_row_t wdata,
  input  logic [IDX_W-1:0]   raddr,
  output gtt_pkg::slot_row_t rdata
);
  import gtt_pkg::*;

  slot_row_t mem [SLOT_COUNT];
  slot_row_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/gtt_slot_eval.sv -----
// gtt_slot_eval: shared evaluation unit, checks one slot row for an action
// and forms the new row, status, reply fields and counter updates
// depends on gtt_pkg
module gtt_slot_eval (
  input  gtt_pkg::action_t              act,
  input  gtt_pkg::slot_row_t            row,
  input  logic [gtt_pkg::GEN_W-1:0]     gen_q,
  input  logic [gtt_pkg::TAG_W-1:0]     tag_q,
  output gtt_pkg::eval_res_t            res
);
  import gtt_pkg::*;

  logic match;

  assign match = row.occupied && (row.generation == gen_q);

  always_comb begin
    res        = '0;
    res.row    = row;
    res.status = STAT_OK;
    unique case (act)
      ACT_SUBMIT: begin
        if (!row.occupied) begin
          res.hit            = 1'b1;
          res.we             = 1'b1;
          res.row.occupied   = 1'b1;
          res.row.phase      = PHASE_PENDING;
          res.row.tag        = tag_q;
          res.row.generation = (row.generation == '0) ? GEN_FIRST : row.generation;
          res.gen            = res.row.generation;
          res.live_inc       = 1'b1;
          res.pend_inc       = 1'b1;
        end
      end
      ACT_POLL: begin
        if (!match) begin
          res.status = STAT_INVALID;
        end else if (row.phase == PHASE_PENDING) begin
          res.we        = 1'b1;
          res.row.phase = PHASE_READY;
          res.pend_dec  = 1'b1;
          res.rdy_inc   = 1'b1;
        end
      end
      ACT_RETIRE: begin
        if (!match) begin
          res.status = STAT_INVALID;
        end else if (row.phase != PHASE_READY) begin
          res.status = STAT_NOT_RETIRABLE;
        end else begin
          res.we             = 1'b1;
          res.row.occupied   = 1'b0;
          res.row.phase      = PHASE_RETIRED;
          res.row.tag        = '0;
          res.row.generation = (row.generation == GEN_MAX) ? GEN_FIRST
                                                           : row.generation + GEN_FIRST;
          res.rdy_dec        = 1'b1;
          res.live_dec       = 1'b1;
        end
      end
      ACT_QUERY: begin
        if (!match) begin
          res.status = STAT_INVALID;
          res.state  = PHASE_INVALID;
        end else begin
          res.state = row.phase;
          res.tag   = row.tag;
        end
      end
      default: begin
        res.status = STAT_INVALID;
      end
    endcase
  end

endmodule
